>>> rtl/core/bgi_pkg.sv
`timescale 1ns / 1ps

package bgi_pkg;

  typedef enum logic [1:0] {
    REQ_WR_ENERGY = 2'd0,
    REQ_WR_TIME   = 2'd1,
    REQ_WR_GRID   = 2'd2,
    REQ_QUERY     = 2'd3
  } req_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_DEGEN = 2'd2;

  localparam int DIV_NUM_W = 49;
  localparam int DIV_DEN_W = 33;
  localparam logic [30:0] RATIO_LIM = 31'h4000_0000;

  typedef struct packed {
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic                 neg;
  } div_req_t;

  function automatic div_req_t mk_div_req(input logic signed [32:0] num,
                                          input logic signed [32:0] den);
    div_req_t r;
    logic [32:0] nm;
    logic [32:0] dm;
    nm = num[32] ? 33'(-num) : 33'(num);
    dm = den[32] ? 33'(-den) : 33'(den);
    r.num = {nm, 16'h0000};
    r.den = dm;
    r.neg = num[32] ^ den[32];
    return r;
  endfunction

  function automatic logic signed [31:0] blend_fin(input logic signed [63:0] s);
    logic signed [63:0] a;
    logic signed [47:0] q;
    logic signed [31:0] r;
    a = s[63] ? s + 64'sd65535 : s;
    q = a[63:16];
    if (q > 48'sh0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (q < -48'sh0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = q[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/bilinear_grid_interpolation_unit.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o | req_type_i index_i write_value_i query_*_i
// out     | output    | out_valid_o / out_stall_i | result_o status_o
// cfg     | input     | APB psel/penable/pready | energy_points at 0x0, time_points at 0x4
// Writes are taken in the idle state and give no result. A query scans the energy
// and time axes, reads the four grid corners, then runs the two serial dividers
// (energy and time, 49 steps each, two ratios each) and the blend.
// Reset clears control and sets the point counts to 64; the memories are not cleared.
// A stalled result is held in the output register while the next item is taken.

module bilinear_grid_interpolation_unit #(
  parameter int MAX_ENERGY_POINTS = 64,
  parameter int MAX_TIME_POINTS   = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [11:0]        index_i,
  input  logic signed [31:0] write_value_i,
  input  logic signed [31:0] query_energy_i,
  input  logic signed [31:0] query_time_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_o,
  output logic [1:0]         status_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import bgi_pkg::*;

  localparam int GD   = MAX_ENERGY_POINTS * MAX_TIME_POINTS;
  localparam int EAW  = $clog2(MAX_ENERGY_POINTS);
  localparam int TAW  = $clog2(MAX_TIME_POINTS);
  localparam int GAW  = $clog2(GD);
  localparam int NEW  = $clog2(MAX_ENERGY_POINTS + 1);
  localparam int NTW  = $clog2(MAX_TIME_POINTS + 1);
  localparam int MAXP = (MAX_ENERGY_POINTS > MAX_TIME_POINTS) ?
                        MAX_ENERGY_POINTS : MAX_TIME_POINTS;
  localparam int CW   = $clog2(MAXP) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_R0, S_R1, S_SCAN, S_ROW, S_GRD, S_DS0, S_DW0, S_DS1, S_DW1, S_BL, S_OUT
  } state_e;

  state_e state_q;

  logic [6:0] energy_points_q;
  logic [6:0] time_points_q;
  logic       cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {25'd0, time_points_q} : {25'd0, energy_points_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_points_q <= 7'd64;
      time_points_q   <= 7'd64;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        time_points_q <= pwdata[6:0];
      end else begin
        energy_points_q <= pwdata[6:0];
      end
    end
  end

  logic [NEW-1:0] npe;
  logic [NTW-1:0] npt;
  logic [EAW-1:0] le;
  logic [TAW-1:0] lt;

  always_comb begin
    if (energy_points_q < 7'd2) begin
      npe = NEW'(2);
    end else if (32'(energy_points_q) > 32'(MAX_ENERGY_POINTS)) begin
      npe = NEW'(MAX_ENERGY_POINTS);
    end else begin
      npe = NEW'(energy_points_q);
    end
    if (time_points_q < 7'd2) begin
      npt = NTW'(2);
    end else if (32'(time_points_q) > 32'(MAX_TIME_POINTS)) begin
      npt = NTW'(MAX_TIME_POINTS);
    end else begin
      npt = NTW'(time_points_q);
    end
    le = EAW'(npe - 1'b1);
    lt = TAW'(npt - 1'b1);
  end

  logic accept;
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = state_q != S_IDLE;

  logic signed [31:0] qe_q, qt_q;
  logic               lo_oor_q;
  logic [CW-1:0]      cnt_q, didx_q;
  logic               dv_q;
  logic               e_done_q, t_done_q;
  logic signed [31:0] e_lo_q, e_hi_q, t_lo_q, t_hi_q;
  logic [EAW-1:0]     i_q;
  logic [TAW-1:0]     j_q;
  logic [GAW-1:0]     rb0_q;
  logic [2:0]         gc_q;
  logic signed [31:0] v_q [4];
  logic signed [31:0] re0_q, re1_q, rt0_q, rt1_q;
  logic signed [31:0] lo_q, hi_q;
  logic [2:0]         bc_q;
  logic signed [63:0] prod_q, acc_q;
  logic signed [31:0] res_pend_q;
  logic [1:0]         st_pend_q;
  logic               out_valid_q;
  logic signed [31:0] result_q;
  logic [1:0]         status_q;

  logic [EAW-1:0] e_raddr;
  logic [TAW-1:0] t_raddr;
  logic [GAW-1:0] g_raddr;
  logic [31:0]    e_rdata, t_rdata, g_rdata;
  logic signed [31:0] ed, td, gd;

  assign ed = $signed(e_rdata);
  assign td = $signed(t_rdata);
  assign gd = $signed(g_rdata);

  always_comb begin
    case (state_q)
      S_R0: begin
        e_raddr = le;
        t_raddr = lt;
      end
      S_SCAN: begin
        e_raddr = (cnt_q > CW'(le)) ? le : cnt_q[EAW-1:0];
        t_raddr = (cnt_q > CW'(lt)) ? lt : cnt_q[TAW-1:0];
      end
      default: begin
        e_raddr = '0;
        t_raddr = '0;
      end
    endcase
  end

  logic [GAW-1:0] rb1;
  assign rb1 = rb0_q + GAW'(npe);

  always_comb begin
    case (gc_q)
      3'd0:    g_raddr = rb0_q + GAW'(i_q) - 1'b1;
      3'd1:    g_raddr = rb0_q + GAW'(i_q);
      3'd2:    g_raddr = rb1 + GAW'(i_q) - 1'b1;
      default: g_raddr = rb1 + GAW'(i_q);
    endcase
  end

  bgi_ram #(.WIDTH(32), .DEPTH(MAX_ENERGY_POINTS)) u_energy_ram (
    .clk_i  (clk_i),
    .we_i   (accept && req_type_i == REQ_WR_ENERGY &&
             32'(index_i) < 32'(MAX_ENERGY_POINTS)),
    .waddr_i(EAW'(index_i)),
    .wdata_i(write_value_i),
    .raddr_i(e_raddr),
    .rdata_o(e_rdata)
  );

  bgi_ram #(.WIDTH(32), .DEPTH(MAX_TIME_POINTS)) u_time_ram (
    .clk_i  (clk_i),
    .we_i   (accept && req_type_i == REQ_WR_TIME &&
             32'(index_i) < 32'(MAX_TIME_POINTS)),
    .waddr_i(TAW'(index_i)),
    .wdata_i(write_value_i),
    .raddr_i(t_raddr),
    .rdata_o(t_rdata)
  );

  bgi_ram #(.WIDTH(32), .DEPTH(GD)) u_grid_ram (
    .clk_i  (clk_i),
    .we_i   (accept && req_type_i == REQ_WR_GRID && 32'(index_i) < 32'(GD)),
    .waddr_i(GAW'(index_i)),
    .wdata_i(write_value_i),
    .raddr_i(g_raddr),
    .rdata_o(g_rdata)
  );

  logic               div_start;
  div_req_t           e_req, t_req;
  logic               e_div_done, t_div_done;
  logic signed [31:0] e_ratio, t_ratio;

  assign div_start = (state_q == S_DS0) || (state_q == S_DS1);

  always_comb begin
    if (state_q == S_DS0) begin
      e_req = mk_div_req(33'(e_hi_q) - 33'(qe_q), 33'(e_hi_q) - 33'(e_lo_q));
      t_req = mk_div_req(33'(t_hi_q) - 33'(qt_q), 33'(t_hi_q) - 33'(t_lo_q));
    end else begin
      e_req = mk_div_req(33'(qe_q) - 33'(e_lo_q), 33'(e_hi_q) - 33'(e_lo_q));
      t_req = mk_div_req(33'(qt_q) - 33'(t_lo_q), 33'(t_hi_q) - 33'(t_lo_q));
    end
  end

  bgi_div u_energy_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .req_i  (e_req),
    .done_o (e_div_done),
    .ratio_o(e_ratio)
  );

  bgi_div u_time_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .req_i  (t_req),
    .done_o (t_div_done),
    .ratio_o(t_ratio)
  );

  logic signed [31:0] opa, opb;
  logic signed [31:0] fin;

  always_comb begin
    case (bc_q)
      3'd0: begin
        opa = re0_q;
        opb = v_q[0];
      end
      3'd1: begin
        opa = re1_q;
        opb = v_q[1];
      end
      3'd2: begin
        opa = re0_q;
        opb = v_q[2];
      end
      3'd3: begin
        opa = re1_q;
        opb = v_q[3];
      end
      3'd4: begin
        opa = rt0_q;
        opb = lo_q;
      end
      3'd5: begin
        opa = rt1_q;
        opb = hi_q;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign fin = blend_fin(acc_q + prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      dv_q        <= 1'b0;
      e_done_q    <= 1'b0;
      t_done_q    <= 1'b0;
      gc_q        <= '0;
      bc_q        <= '0;
      cnt_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept && req_type_i == REQ_QUERY) begin
            qe_q    <= query_energy_i;
            qt_q    <= query_time_i;
            state_q <= S_R0;
          end
        end
        S_R0: begin
          lo_oor_q <= (qe_q < ed) || (qt_q < td);
          state_q  <= S_R1;
        end
        S_R1: begin
          if (lo_oor_q || qe_q > ed || qt_q > td) begin
            res_pend_q <= '0;
            st_pend_q  <= ST_RANGE;
            state_q    <= S_OUT;
          end else begin
            cnt_q    <= '0;
            dv_q     <= 1'b0;
            e_done_q <= 1'b0;
            t_done_q <= 1'b0;
            state_q  <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt_q  <= cnt_q + 1'b1;
          didx_q <= cnt_q;
          dv_q   <= 1'b1;
          if (dv_q && !e_done_q) begin
            if (didx_q < CW'(le) && qe_q >= ed) begin
              e_lo_q <= ed;
            end else begin
              e_hi_q   <= ed;
              i_q      <= didx_q[EAW-1:0];
              e_done_q <= 1'b1;
            end
          end
          if (dv_q && !t_done_q) begin
            if (didx_q < CW'(lt) && qt_q >= td) begin
              t_lo_q <= td;
            end else begin
              t_hi_q   <= td;
              j_q      <= didx_q[TAW-1:0];
              t_done_q <= 1'b1;
            end
          end
          if (e_done_q && t_done_q) begin
            if (e_lo_q == e_hi_q || t_lo_q == t_hi_q) begin
              res_pend_q <= '0;
              st_pend_q  <= ST_DEGEN;
              state_q    <= S_OUT;
            end else begin
              state_q <= S_ROW;
            end
          end
        end
        S_ROW: begin
          rb0_q   <= GAW'(j_q - 1'b1) * GAW'(npe);
          gc_q    <= '0;
          state_q <= S_GRD;
        end
        S_GRD: begin
          gc_q <= gc_q + 1'b1;
          if (gc_q != '0) begin
            v_q[2'(gc_q - 3'd1)] <= gd;
          end
          if (gc_q == 3'd4) begin
            state_q <= S_DS0;
          end
        end
        S_DS0: begin
          state_q <= S_DW0;
        end
        S_DW0: begin
          if (e_div_done) begin
            re0_q   <= e_ratio;
            rt0_q   <= t_ratio;
            state_q <= S_DS1;
          end
        end
        S_DS1: begin
          state_q <= S_DW1;
        end
        S_DW1: begin
          if (e_div_done) begin
            re1_q   <= e_ratio;
            rt1_q   <= t_ratio;
            bc_q    <= '0;
            state_q <= S_BL;
          end
        end
        S_BL: begin
          bc_q   <= bc_q + 1'b1;
          prod_q <= opa * opb;
          case (bc_q)
            3'd1, 3'd3, 3'd5: acc_q <= prod_q;
            3'd2: lo_q <= fin;
            3'd4: hi_q <= fin;
            3'd6: begin
              res_pend_q <= fin;
              st_pend_q  <= ST_OK;
              state_q    <= S_OUT;
            end
            default: begin
            end
          endcase
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            result_q    <= res_pend_q;
            status_q    <= st_pend_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign status_o    = status_q;

  a_div_lockstep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_div_done == t_div_done) else $error("energy and time dividers out of step");
  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && dv_q && !e_done_q) |-> didx_q <= CW'(le))
    else $error("energy scan ran past the last point");
  a_corner_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROW |-> (i_q != '0 && j_q != '0))
    else $error("interval index zero after scan");

endmodule

>>> rtl/core/bgi_ram.sv
`timescale 1ns / 1ps

module bgi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/bgi_div.sv
`timescale 1ns / 1ps

module bgi_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  bgi_pkg::div_req_t   req_i,
  output logic                done_o,
  output logic signed [31:0]  ratio_o
);

  import bgi_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [CNT_W-1:0]     cnt_q;
  logic                 done_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic                 neg_q;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;
  logic [30:0]          mag;

  assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(DIV_NUM_W);
        quo_q <= req_i.num;
        den_q <= req_i.den;
        neg_q <= req_i.neg;
        rem_q <= '0;
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        rem_q  <= fits ? DIV_DEN_W'(trial - {1'b0, den_q}) : DIV_DEN_W'(trial);
        quo_q  <= {quo_q[DIV_NUM_W-2:0], fits};
        done_q <= cnt_q == CNT_W'(1);
      end
    end
  end

  assign mag     = (quo_q > DIV_NUM_W'(RATIO_LIM)) ? RATIO_LIM : quo_q[30:0];
  assign ratio_o = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign done_o  = done_q;

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> cnt_q == '0) else $error("divider restarted while busy");
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> cnt_q == '0) else $error("divider done while still iterating");
  a_start_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> cnt_q == CNT_W'(DIV_NUM_W)) else $error("divider count not loaded");

endmodule
